// ----- rtl/core/ssps_pkg.sv -----
// ----------------------------------------------------------------------------
// ssps_pkg
// Shared types and constants of the slotted servo pulse scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ssps_pkg;

    localparam int CHANNELS    = 8;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TABLE_DEPTH = 8;
    localparam int TABLE_W     = 3;
    localparam int PIN_W       = 8;
    localparam int TICK_W      = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD_LAST = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT_LEN    = 1'd1;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [TICK_W-1:0] PERIOD_LAST_RST = 16'd12499;
    localparam logic [TICK_W-1:0] SLOT_LEN_RST    = 16'd1562;

    typedef struct packed {
        logic [2:0]       active_channel;
        logic             edge_event;
        logic [PIN_W-1:0] pins;
    } t_result;

    typedef logic [1:0] t_fill;

endpackage

`default_nettype wire

// ----- rtl/core/slotted_servo_pulse_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// slotted_servo_pulse_scheduler_top
// Drives a group of servo pins in time slots of a wrapping period counter.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis channel. s_axis_tuser is the operation: low for
// one timer tick, high to store a channel's pulse width. s_axis_tdata holds
// the channel number and the pulse width of a write.
// Every item gives exactly one result on the m_axis channel: the pin levels,
// a flag for a compare event on this tick and the channel being served.
// The counter, compare and table are updated in the cycle of the transfer,
// and the result is registered in the output buffer and shown from its head.
// One item per clock is accepted for as long as results are taken. A
// two-entry output buffer lets the block take one more transfer while a
// result waits; s_axis_tready drops only when both entries are full.
// The configuration port writes the period and the slot length registers; the
// user must write it only while no item is in flight; the block does not enforce it.
// A synchronous reset clears the counter, compare, channel, width table and
// pins, arms the rising event and loads the default period and slot length.
// The output buffer is emptied by reset.
// ----------------------------------------------------------------------------
`default_nettype none

module slotted_servo_pulse_scheduler_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [ssps_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [ssps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [2:0] channel, [18:3] pulse_width, [23:19] zero
    input  wire logic [23:0]                         s_axis_tdata,
    // [0] operation
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [7:0] pins, [8] edge_event, [11:9] active_channel, [15:12] zero
    output logic [15:0]                              m_axis_tdata
);

    localparam int CH_W   = ssps_pkg::CH_W;
    localparam int TICK_W = ssps_pkg::TICK_W;

    logic [TICK_W-1:0]          r_period_last;
    logic [TICK_W-1:0]          r_slot_len;
    logic [TICK_W-1:0]          r_counter;
    logic [TICK_W-1:0]          r_compare;
    logic [CH_W-1:0]            r_chan;
    logic                       r_rising;
    logic [ssps_pkg::PIN_W-1:0] r_pins;
    logic [TICK_W-1:0]          r_table [ssps_pkg::TABLE_DEPTH];

    logic [TICK_W-1:0]          n_counter;
    logic [TICK_W-1:0]          n_compare;
    logic [CH_W-1:0]            n_chan;
    logic                       n_rising;
    logic [ssps_pkg::PIN_W-1:0] n_pins;
    logic                       n_event;

    ssps_pkg::t_result          r_head;
    ssps_pkg::t_result          r_skid;
    ssps_pkg::t_fill            r_fill;
    ssps_pkg::t_result          result;

    logic                       push;
    logic                       pop;
    logic                       is_tick;
    logic [2:0]                 in_chan;
    logic [TICK_W-1:0]          in_width;
    logic                       last_chan;
    logic [CH_W:0]              chan_inc;
    logic [ssps_pkg::PIN_W-1:0] pin_mask;
    logic [TICK_W-1:0]          slot_start;
    logic                       write_ok;

    assign push     = s_axis_tvalid && s_axis_tready;
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign is_tick  = (s_axis_tuser == ssps_pkg::OP_TICK);
    assign in_chan  = s_axis_tdata[2:0];
    assign in_width = s_axis_tdata[18:3];
    assign write_ok = (s_axis_tuser == ssps_pkg::OP_WRITE)
                      && (5'(in_chan) < 5'(ssps_pkg::CHANNELS));

    assign last_chan  = (r_chan == CH_W'(ssps_pkg::CHANNELS - 1));
    assign chan_inc   = {1'b0, r_chan} + (CH_W + 1)'(1);
    assign slot_start = TICK_W'(r_slot_len * TICK_W'(chan_inc));
    assign pin_mask   = ((CH_W + 1)'(r_chan) < (CH_W + 1)'(8))
                        ? (ssps_pkg::PIN_W'(1) << 3'(r_chan))
                        : '0;

    always_comb begin
        n_counter = r_counter;
        n_compare = r_compare;
        n_chan    = r_chan;
        n_rising  = r_rising;
        n_pins    = r_pins;
        n_event   = 1'b0;
        if (is_tick) begin
            if (r_counter >= r_period_last) begin
                n_counter = '0;
            end else begin
                n_counter = r_counter + TICK_W'(1);
            end
            if (n_counter == r_compare) begin
                n_event = 1'b1;
                if (r_rising) begin
                    n_pins    = r_pins | pin_mask;
                    n_compare = r_compare + r_table[ssps_pkg::TABLE_W'(r_chan)];
                    n_rising  = 1'b0;
                end else begin
                    n_pins    = r_pins & ~pin_mask;
                    n_rising  = 1'b1;
                    n_compare = last_chan ? '0 : slot_start;
                    n_chan    = last_chan ? '0 : CH_W'(chan_inc);
                end
            end
        end
    end

    always_comb begin
        result.pins           = n_pins;
        result.edge_event     = n_event;
        result.active_channel = 3'(n_chan);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_last <= ssps_pkg::PERIOD_LAST_RST;
            r_slot_len    <= ssps_pkg::SLOT_LEN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ssps_pkg::CFG_PERIOD_LAST: r_period_last <= i_cfg_data;
                ssps_pkg::CFG_SLOT_LEN:    r_slot_len    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counter <= '0;
            r_compare <= '0;
            r_chan    <= '0;
            r_rising  <= 1'b1;
            r_pins    <= '0;
            for (int i = 0; i < ssps_pkg::TABLE_DEPTH; i++) begin
                r_table[i] <= '0;
            end
        end else if (push) begin
            r_counter <= n_counter;
            r_compare <= n_compare;
            r_chan    <= n_chan;
            r_rising  <= n_rising;
            r_pins    <= n_pins;
            if (write_ok) begin
                r_table[in_chan] <= in_width;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 2'd0;
        end else if (push && !pop) begin
            r_fill <= r_fill + 2'd1;
        end else if (!push && pop) begin
            r_fill <= r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push && !pop) begin
            if (r_fill == 2'd0) begin
                r_head <= result;
            end else begin
                r_skid <= result;
            end
        end else if (push && pop) begin
            if (r_fill == 2'd1) begin
                r_head <= result;
            end else begin
                r_head <= r_skid;
                r_skid <= result;
            end
        end else if (pop) begin
            r_head <= r_skid;
        end
    end

    assign s_axis_tready = (r_fill != 2'd2);
    assign m_axis_tvalid = (r_fill != 2'd0);
    assign m_axis_tdata  = {4'b0000, r_head};

endmodule

`default_nettype wire

// ----- tb/tb_slotted_servo_pulse_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// tb_slotted_servo_pulse_scheduler_top
// Self-checking bench for the slotted servo pulse scheduler. Ticks and width
// writes are streamed in under several period and slot settings. A scoreboard
// predicts the pin levels, the compare event flag and the served channel of
// every transfer and checks each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_slotted_servo_pulse_scheduler_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ssps_pkg::*;

    class servo_scoreboard;
        bit [TICK_W-1:0] period_last;
        bit [TICK_W-1:0] slot_len;
        bit [TICK_W-1:0] counter;
        bit [TICK_W-1:0] compare;
        bit [2:0]        chan;
        bit              rising;
        bit [TICK_W-1:0] widths [TABLE_DEPTH];
        bit [PIN_W-1:0]  pins;
        t_result         expected_q[$];
        int              errors;
        int              ticks;
        int              writes;
        int              edges;
        int              checked;

        function new();
            period_last = PERIOD_LAST_RST;
            slot_len    = SLOT_LEN_RST;
            counter     = '0;
            compare     = '0;
            chan        = '0;
            rising      = 1'b1;
            pins        = '0;
            foreach (widths[i]) widths[i] = '0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            if (addr == CFG_PERIOD_LAST) period_last = data;
            else if (addr == CFG_SLOT_LEN) slot_len = data;
        endfunction

        function void serve_compare();
            int next_ch;
            next_ch = int'(chan) + 1;
            if (rising) begin
                pins    = pins | (PIN_W'(1) << chan);
                compare = compare + widths[chan];
                rising  = 1'b0;
            end else begin
                pins = pins & ~(PIN_W'(1) << chan);
                if (next_ch < CHANNELS) compare = TICK_W'(int'(slot_len) * next_ch);
                else compare = '0;
                rising = 1'b1;
                chan   = (next_ch >= CHANNELS) ? 3'd0 : 3'(next_ch);
            end
        endfunction

        function void note_input(logic op, logic [2:0] ch, logic [TICK_W-1:0] pw);
            t_result r;
            r.edge_event = 1'b0;
            if (op == OP_WRITE) begin
                writes++;
                if (int'(ch) < CHANNELS) widths[ch] = pw;
            end else begin
                ticks++;
                if (counter >= period_last) counter = '0;
                else counter = counter + 1'b1;
                if (counter == compare) begin
                    serve_compare();
                    r.edge_event = 1'b1;
                    edges++;
                end
            end
            r.pins           = pins;
            r.active_channel = chan;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t ns: %s", $time, what);
            errors++;
        endtask

        task check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                exp = expected_q.pop_front();
                checked++;
                if (got.pins != exp.pins)
                    report_mismatch($sformatf("pins %02h, expected %02h", got.pins, exp.pins));
                if (got.edge_event != exp.edge_event)
                    report_mismatch($sformatf("edge_event %0d, expected %0d",
                                              got.edge_event, exp.edge_event));
                if (got.active_channel != exp.active_channel)
                    report_mismatch($sformatf("active_channel %0d, expected %0d",
                                              got.active_channel, exp.active_channel));
            end
        endtask
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  s_axis_tvalid  = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata   = '0;
    logic                  s_axis_tuser   = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready  = 1'b0;
    logic [15:0]           m_axis_tdata;

    servo_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    slotted_servo_pulse_scheduler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_reg(i_cfg_addr, i_cfg_data);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(t_result'(m_axis_tdata[11:0]));
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[18:3]);
        end
    end

    task write_cfg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task send_item(logic op, logic [2:0] ch, logic [TICK_W-1:0] pw);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, pw, ch};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task drain_burst();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int period_set [6] = '{1, 20, 40, 60, 100, 65535};
        int slot_set   [6] = '{0, 2, 5, 7, 12, 65535};
        bit [TICK_W-1:0] first_widths [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'hAAAA,
                                               16'h5555, 16'h0002, 16'h0000, 16'h0003};
        bit [TICK_W-1:0] pw;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Short period so that the first compare event falls inside the
        // directed items; zero and full-scale widths are both stored.
        write_cfg(CFG_PERIOD_LAST, 16'd9);
        write_cfg(CFG_SLOT_LEN, 16'd1);
        for (int c = 0; c < 8; c++) send_item(OP_WRITE, 3'(c), first_widths[c]);
        for (int t = 0; t < 16; t++) send_item(OP_TICK, 3'($urandom), 16'($urandom));
        drain_burst();

        // Periods grow from phase to phase, so a compare left over from the
        // previous setting is always reachable again.
        for (int ph = 0; ph < 6; ph++) begin
            send_idle_pct = (ph < 2) ? 33 : (ph < 4) ? 73 : 0;
            recv_idle_pct = (ph < 2) ? 73 : (ph < 4) ? 33 : 0;
            write_cfg(CFG_PERIOD_LAST, 16'(period_set[ph]));
            write_cfg(CFG_SLOT_LEN, 16'(slot_set[ph]));
            for (int c = 0; c < 8; c++) begin
                pw = (ph == 5) ? 16'($urandom) : 16'($urandom_range(0, 3));
                send_item(OP_WRITE, 3'(c), pw);
            end
            for (int n = 0; n < 85; n++) begin
                if ($urandom_range(0, 99) < 25) begin
                    pw = (ph == 5) ? 16'($urandom) : 16'($urandom_range(0, 3));
                    send_item(OP_WRITE, 3'($urandom), pw);
                end else begin
                    send_item(OP_TICK, 3'($urandom), 16'($urandom));
                end
            end
            drain_burst();
        end

        repeat (10) @(posedge i_clk);
        $display("Checked %0d results: %0d ticks, %0d width writes, %0d compare events.",
                 sb.checked, sb.ticks, sb.writes, sb.edges);
        $display("Periods from 1 to 65535 and slot lengths from 0 to 65535 were exercised.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
